@@ rtl/sal_pkg.sv @@
// sal_pkg: shared types and constants of the shifting array list.
// Holds command codes, status codes, beat payload structs and cell control.
// No dependencies.
package sal_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int POS_W      = 4;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COMPARE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_OOB   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             match;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_t;

  // Broadcast to every cell in the row each cycle.
  typedef struct packed {
    cell_op_t              op;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] wdata;
  } cell_ctrl_t;

endpackage

@@ rtl/shifting_array_list.sv @@
// shifting_array_list: top level of the ordered word list built as a row of
// sal_cell slots with a central command decoder and result register.
// Depends on sal_pkg and sal_cell.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_item           | beat taken when start & !busy
//  result  | out_strobe, out_item           | one-cycle strobe, no backpressure
//  config  | cfg_wr_en, cfg_wr_data         | write when cfg_wr_en is high
//
// The result beat appears on the cycle after the input beat is taken, and
// busy stays low, so a new command may follow every cycle. All cells shift
// from their neighbors, load or hold in parallel. Synchronous reset empties
// the list (count goes to zero; cell contents are left as they are) and sets
// the capacity limit to DEPTH. The receiver cannot stall results.
module shifting_array_list (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  sal_pkg::in_item_t        in_item,
  output logic                     out_strobe,
  output sal_pkg::out_item_t       out_item,
  input  logic                     cfg_wr_en,
  input  logic [sal_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int CNT_W = sal_pkg::CNT_W;
  localparam int DW    = sal_pkg::DATA_WIDTH;
  localparam int DEPTH = sal_pkg::DEPTH;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic [sal_pkg::CAP_W-1:0] cap_r;
  logic                    out_strobe_r;
  sal_pkg::out_item_t      out_item_r;
  sal_pkg::out_item_t      out_item_nxt;

  logic                    accept;
  logic [CNT_W-1:0]        cap_eff;
  logic [CNT_W-1:0]        pos_ext;
  logic                    full_now;
  logic                    pos_oob;
  logic                    hit_any;
  sal_pkg::cell_ctrl_t     ctrl;

  logic [DW-1:0]           cell_data [DEPTH];
  logic [DW-1:0]           left_in   [DEPTH];
  logic [DW-1:0]           right_in  [DEPTH];
  logic [DEPTH-1:0]        cell_hit;

  // The list never makes the issuer wait.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp the capacity: zero acts as one, anything above DEPTH acts as DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if ({{(32-sal_pkg::CAP_W){1'b0}}, cap_r} > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign pos_ext  = CNT_W'(in_item.position);
  assign full_now = count_r >= cap_eff;
  assign pos_oob  = pos_ext >= count_r;
  assign hit_any  = |cell_hit;

  // Decode the command: pick the status, the new count and the cell action.
  always_comb begin
    count_nxt  = count_r;
    ctrl.op    = sal_pkg::CELL_HOLD;
    ctrl.pos   = pos_ext;
    ctrl.count = count_r;
    ctrl.wdata = DW'(in_item.value);
    out_item_nxt.status = sal_pkg::ST_OK;
    out_item_nxt.match  = 1'b0;
    if (accept) begin
      case (in_item.command)
        sal_pkg::CMD_APPEND: begin
          if (full_now) begin
            out_item_nxt.status = sal_pkg::ST_FULL;
          end else begin
            ctrl.op   = sal_pkg::CELL_WRITE;
            ctrl.pos  = count_r;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        sal_pkg::CMD_INSERT: begin
          if (full_now) begin
            out_item_nxt.status = sal_pkg::ST_FULL;
          end else if (pos_ext > count_r) begin
            out_item_nxt.status = sal_pkg::ST_OOB;
          end else begin
            ctrl.op   = sal_pkg::CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        sal_pkg::CMD_REMOVE: begin
          if (count_r == '0) begin
            out_item_nxt.status = sal_pkg::ST_EMPTY;
          end else if (pos_oob) begin
            out_item_nxt.status = sal_pkg::ST_OOB;
          end else begin
            ctrl.op   = sal_pkg::CELL_REMOVE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        sal_pkg::CMD_REPLACE: begin
          if (pos_oob) begin
            out_item_nxt.status = sal_pkg::ST_OOB;
          end else begin
            ctrl.op = sal_pkg::CELL_WRITE;
          end
        end
        sal_pkg::CMD_COMPARE: begin
          // an empty list makes every position out of bounds
          if (pos_oob) begin
            out_item_nxt.status = sal_pkg::ST_OOB;
          end else begin
            out_item_nxt.match = hit_any;
          end
        end
        sal_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // unused codes: drop, report ok
          count_nxt = count_r;
        end
      endcase
    end
    out_item_nxt.count    = count_nxt;
    out_item_nxt.is_empty = (count_nxt == '0);
    out_item_nxt.is_full  = (count_nxt >= cap_eff);
  end

  // Neighbor wiring: ends of the row feed back harmless values.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_in[i]  = (i == 0)         ? ctrl.wdata    : cell_data[(i == 0) ? 0 : i - 1];
      right_in[i] = (i == DEPTH - 1) ? cell_data[i]  : cell_data[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sal_cell u_cell (
      .clk        (clk),
      .cell_idx   (CNT_W'(g)),
      .ctrl       (ctrl),
      .left_data  (left_in[g]),
      .right_data (right_in[g]),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  // Control state: count, capacity and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cap_r        <= sal_pkg::CAP_W'(DEPTH);
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // Result payload: hold until the next command overwrites it.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ rtl/sal_cell.sv @@
// sal_cell: one storage slot of the list; takes a word from either neighbor
// on a shift, loads the command word on a write, and flags a compare hit.
// Depends on sal_pkg.
module sal_cell (
  input  logic                            clk,
  input  logic [sal_pkg::CNT_W-1:0]       cell_idx,
  input  sal_pkg::cell_ctrl_t             ctrl,
  input  logic [sal_pkg::DATA_WIDTH-1:0]  left_data,
  input  logic [sal_pkg::DATA_WIDTH-1:0]  right_data,
  output logic [sal_pkg::DATA_WIDTH-1:0]  data,
  output logic                            hit
);

  logic [sal_pkg::DATA_WIDTH-1:0] data_r;
  logic [sal_pkg::DATA_WIDTH-1:0] data_nxt;
  logic [sal_pkg::CNT_W-1:0]      idx_inc;

  assign idx_inc = cell_idx + sal_pkg::CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      sal_pkg::CELL_INSERT: begin
        // open a gap at pos: cells above it take from below
        if (cell_idx == ctrl.pos) begin
          data_nxt = ctrl.wdata;
        end else if (cell_idx > ctrl.pos && cell_idx <= ctrl.count) begin
          data_nxt = left_data;
        end
      end
      sal_pkg::CELL_REMOVE: begin
        // close the gap: cells from pos up take from above
        if (cell_idx >= ctrl.pos && idx_inc < ctrl.count) begin
          data_nxt = right_data;
        end
      end
      sal_pkg::CELL_WRITE: begin
        if (cell_idx == ctrl.pos) begin
          data_nxt = ctrl.wdata;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (cell_idx == ctrl.pos) && (data_r == ctrl.wdata);

endmodule
